// File: rtl/sticky_modifier_window_cycler_top_assert.svh
// Assertion macros shared by the sticky modifier window cycler modules.
// Needs nothing but a clock and an active-low reset at the point of use.
`ifndef STICKY_MODIFIER_WINDOW_CYCLER_TOP_ASSERT_SVH
`define STICKY_MODIFIER_WINDOW_CYCLER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SMWC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("smwc assertion failed");

// Next-cycle implication, checked outside reset.
`define SMWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smwc assertion failed");

`endif

// File: rtl/smwc_pkg.sv
// Types and constants of the sticky modifier window cycler.
// Used by every module of the block; depends on nothing.
package smwc_pkg;

	// Input kinds.
	localparam logic [2:0] KIND_HOTKEY_PRESS   = 3'd0;
	localparam logic [2:0] KIND_HOTKEY_RELEASE = 3'd1;
	localparam logic [2:0] KIND_KEY            = 3'd2;
	localparam logic [2:0] KIND_LAYER          = 3'd3;
	localparam logic [2:0] KIND_TICK           = 3'd4;

	// Result actions.
	localparam logic [2:0] ACT_KEY         = 3'd0;
	localparam logic [2:0] ACT_ADD_MODS    = 3'd1;
	localparam logic [2:0] ACT_REMOVE_MODS = 3'd2;
	localparam logic [2:0] ACT_HID_PRESS   = 3'd3;
	localparam logic [2:0] ACT_HID_RELEASE = 3'd4;
	localparam logic [2:0] ACT_DISP        = 3'd5;

	// Dispositions.
	localparam logic [1:0] DISP_BUBBLE  = 2'd0;
	localparam logic [1:0] DISP_HANDLED = 2'd1;
	localparam logic [1:0] DISP_OPAQUE  = 2'd2;
	localparam logic [1:0] DISP_NONE    = 2'd3;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PASS    = 8'd1;

	// Keyboard usages.
	localparam logic [7:0]  SHIFT_MASK   = 8'h22;
	localparam logic [7:0]  PAGE_KEY     = 8'h07;
	localparam logic [15:0] ID_ESC       = 16'h0029;
	localparam logic [15:0] ID_LSHIFT    = 16'h00E1;
	localparam logic [15:0] ID_RSHIFT    = 16'h00E5;
	localparam logic [15:0] ID_MOD_FIRST = 16'h00E0;
	localparam logic [15:0] ID_MOD_LAST  = 16'h00E7;
	localparam logic [15:0] ID_NAV_FIRST = 16'h004F;
	localparam logic [15:0] ID_NAV_LAST  = 16'h0052;

	localparam int unsigned MAX_RESULTS = 5;
	localparam int unsigned CNT_W       = 3;
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  hotkey_mods;
		logic [7:0]  hid_page;
		logic [15:0] usage_id;
		logic        is_pressed;
		logic [4:0]  layer;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  mods;
		logic [7:0]  out_page;
		logic [15:0] out_id;
		logic        key_state;
		logic [1:0]  disposition;
		logic        last;
	} out_item_t;

	// All results of one input, in order, and how many there are.
	typedef struct packed {
		out_item_t [MAX_RESULTS-1:0] slot;
		logic [CNT_W-1:0]            cnt;
	} plan_t;

endpackage

// File: rtl/sticky_modifier_window_cycler_top.sv
// Top level of the sticky modifier window cycler: front end, plan queue and
// back end. Depends on smwc_pkg and the modules smwc_front, smwc_queue, smwc_back.
//
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-----------------------------------
// in       | input     | in_valid / in_ready    | in_item (smwc_pkg::in_item_t)
// out      | output    | out_valid / out_ready  | out_item (smwc_pkg::out_item_t)
// cfg      | input     | cfg_valid / cfg_ready  | cfg_index (8 bits), cfg_data (16 bits)
//
// An input item is classified and applied to the cycle state in the cycle of its
// transfer; its results (one to five) go into a two-entry plan queue.
// The back end sends one result per cycle from the queue head through an output
// register, unless out_ready stalls it; each result is registered first in a queue
// entry and then in the output register before it appears on the out channel.
// in_ready drops only while both queue entries are full; cfg_ready is always high.
// Reset is asynchronous and active low; it clears the state and config registers.
module sticky_modifier_window_cycler_top #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  smwc_pkg::in_item_t              in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output smwc_pkg::out_item_t             out_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [smwc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smwc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import smwc_pkg::*;

	plan_t plan, head;
	logic  full, push, pop, head_valid;

	// Configuration writes are always taken; writes to unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	// A transfer on the input channel needs only a free queue entry.
	assign in_ready = !full;
	assign push     = in_valid && in_ready;

	smwc_front #(
		.TIMER_BITS(TIMER_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (in_item),
		.cfg_we   (cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.plan     (plan)
	);

	smwc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_plan (plan),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	smwc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// File: rtl/smwc_front.sv
// Front end: accepts input items, holds the cycle state and config registers,
// and turns each item into a plan of results. Depends on smwc_pkg.
module smwc_front #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  smwc_pkg::in_item_t              item,
	input  logic                            cfg_we,
	input  logic [smwc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smwc_pkg::CFG_DATA_W-1:0] cfg_data,
	output smwc_pkg::plan_t                 plan
);
	import smwc_pkg::*;
	`include "sticky_modifier_window_cycler_top_assert.svh"

	localparam int unsigned CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	logic [15:0]           to_q;
	logic                  pt_q;
	logic                  ca_q, ca_n;
	logic [7:0]            hm_q, hm_n;
	logic [23:0]           hu_q, hu_n;
	logic [31:0]           hk_q, hk_n;
	logic [4:0]            pl_q, pl_n;
	logic                  sd_q, sd_n;
	logic [23:0]           su_q, su_n;
	logic [TIMER_BITS-1:0] ic_q, ic_n, ic_inc;
	logic                  tr_q, tr_n;

	logic [7:0]       hold, tap;
	logic [23:0]      usage;
	logic             is_kp, shift_key, is_mod, is_nav, is_hot, is_esc, sw_hit;
	logic             end_req, esc_tap;
	logic [1:0]       disp;
	logic [CNT_W-1:0] n;

	function automatic out_item_t mk_res(logic [2:0] act, logic [7:0] m, logic [7:0] pg,
			logic [15:0] id, logic ks);
		out_item_t r;
		r = '0;
		r.action    = act;
		r.mods      = m;
		r.out_page  = pg;
		r.out_id    = id;
		r.key_state = ks;
		return r;
	endfunction

	// Timer restarts only outside a press, with a cycle on, no Shift down and a timeout set.
	function automatic logic tmr_run(logic ca, logic pressed, logic sd, logic to_nz);
		return ca && !pressed && !sd && to_nz;
	endfunction

	always_comb begin
		hold      = item.hotkey_mods & ~SHIFT_MASK;
		tap       = item.hotkey_mods & SHIFT_MASK;
		usage     = {item.hid_page, item.usage_id};
		is_kp     = item.hid_page == PAGE_KEY;
		shift_key = is_kp && (item.usage_id == ID_LSHIFT || item.usage_id == ID_RSHIFT);
		is_mod    = is_kp && item.usage_id >= ID_MOD_FIRST && item.usage_id <= ID_MOD_LAST;
		is_nav    = is_kp && item.usage_id >= ID_NAV_FIRST && item.usage_id <= ID_NAV_LAST;
		is_hot    = usage == hu_q;
		is_esc    = is_kp && item.usage_id == ID_ESC;
		sw_hit    = !item.is_pressed && su_q != '0 && usage == su_q;
		ic_inc    = (ic_q == '1) ? ic_q : TIMER_BITS'(ic_q + 1'b1);

		ca_n = ca_q; hm_n = hm_q; hu_n = hu_q; hk_n = hk_q; pl_n = pl_q;
		sd_n = sd_q; su_n = su_q; ic_n = ic_q; tr_n = tr_q;
		plan    = '0;
		n       = '0;
		disp    = DISP_NONE;
		end_req = 1'b0;
		esc_tap = 1'b0;

		// Decide whether this item ends the cycle, and whether Escape is tapped first.
		unique case (item.kind)
			KIND_HOTKEY_PRESS: end_req = ca_q && hm_q != hold;
			KIND_KEY: begin
				if (!sw_hit && ca_q && !shift_key && !is_mod && !is_nav && !is_hot) begin
					end_req = 1'b1;
					esc_tap = item.is_pressed && is_esc;
				end
			end
			KIND_LAYER: end_req = ca_q && !item.is_pressed && item.layer == pl_q;
			KIND_TICK: end_req = tr_q && to_q != '0 && CMP_W'(ic_inc) >= CMP_W'(to_q);
			default: end_req = 1'b0;
		endcase

		if (esc_tap) begin
			plan.slot[n] = mk_res(ACT_HID_PRESS, 8'h00, item.hid_page, item.usage_id, 1'b0);
			n = n + 1'b1;
			plan.slot[n] = mk_res(ACT_HID_RELEASE, 8'h00, item.hid_page, item.usage_id, 1'b0);
			n = n + 1'b1;
		end

		if (end_req && ca_q) begin
			ca_n = 1'b0;
			tr_n = 1'b0;
			if (hk_n != '0) begin
				plan.slot[n] = mk_res(ACT_KEY, hk_n[31:24], hk_n[23:16], hk_n[15:0], 1'b0);
				n = n + 1'b1;
				hk_n = '0;
			end
			if (hm_n != '0) begin
				plan.slot[n] = mk_res(ACT_REMOVE_MODS, hm_n, 8'h00, 16'h0000, 1'b0);
				n = n + 1'b1;
			end
			hm_n = '0;
			sd_n = 1'b0;
		end

		unique case (item.kind)
			KIND_HOTKEY_PRESS: begin
				if (!ca_n) begin
					ca_n = 1'b1;
					hm_n = hold;
					pl_n = item.layer;
					sd_n = 1'b0;
					su_n = '0;
					if (hold != '0) begin
						plan.slot[n] = mk_res(ACT_ADD_MODS, hold, 8'h00, 16'h0000, 1'b0);
						n = n + 1'b1;
					end
				end
				hu_n = usage;
				if (hk_n != '0) begin
					plan.slot[n] = mk_res(ACT_KEY, hk_n[31:24], hk_n[23:16], hk_n[15:0], 1'b0);
					n = n + 1'b1;
				end
				hk_n = {tap, usage};
				plan.slot[n] = mk_res(ACT_KEY, tap, item.hid_page, item.usage_id, 1'b1);
				n = n + 1'b1;
				tr_n = 1'b0;
				disp = DISP_OPAQUE;
			end
			KIND_HOTKEY_RELEASE: begin
				if (hk_n != '0) begin
					plan.slot[n] = mk_res(ACT_KEY, hk_n[31:24], hk_n[23:16], hk_n[15:0], 1'b0);
					n = n + 1'b1;
					hk_n = '0;
				end
				if (tmr_run(ca_n, 1'b0, sd_n, to_q != '0)) begin
					tr_n = 1'b1;
					ic_n = '0;
				end else begin
					tr_n = 1'b0;
				end
				disp = DISP_OPAQUE;
			end
			KIND_KEY: begin
				disp = DISP_BUBBLE;
				priority if (sw_hit) begin
					su_n = '0;
					disp = DISP_HANDLED;
				end else if (!ca_q) begin
					disp = DISP_BUBBLE;
				end else if (shift_key || (!is_mod && (is_nav || is_hot))) begin
					if (shift_key)
						sd_n = item.is_pressed;
					if (tmr_run(ca_n, item.is_pressed, sd_n, to_q != '0)) begin
						tr_n = 1'b1;
						ic_n = '0;
					end else begin
						tr_n = 1'b0;
					end
				end else if (is_mod) begin
					disp = DISP_BUBBLE;
				end else if (esc_tap) begin
					su_n = usage;
					disp = DISP_HANDLED;
				end else if (!item.is_pressed || pt_q) begin
					disp = DISP_BUBBLE;
				end else begin
					su_n = usage;
					disp = DISP_HANDLED;
				end
			end
			KIND_LAYER: disp = DISP_BUBBLE;
			KIND_TICK: begin
				if (tr_q) begin
					if (to_q == '0)
						tr_n = 1'b0;
					else
						ic_n = ic_inc;
				end
				disp = DISP_NONE;
			end
			default: disp = DISP_NONE;
		endcase

		plan.slot[n] = '0;
		plan.slot[n].action      = ACT_DISP;
		plan.slot[n].disposition = disp;
		plan.slot[n].last        = 1'b1;
		plan.cnt = n + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			to_q <= '0;
			pt_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_TIMEOUT)
				to_q <= cfg_data[15:0];
			else if (cfg_index == CFG_PASS)
				pt_q <= cfg_data[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ca_q <= 1'b0;
			hm_q <= '0;
			hu_q <= '0;
			hk_q <= '0;
			pl_q <= '0;
			sd_q <= 1'b0;
			su_q <= '0;
			ic_q <= '0;
			tr_q <= 1'b0;
		end else if (push) begin
			ca_q <= ca_n;
			hm_q <= hm_n;
			hu_q <= hu_n;
			hk_q <= hk_n;
			pl_q <= pl_n;
			sd_q <= sd_n;
			su_q <= su_n;
			ic_q <= ic_n;
			tr_q <= tr_n;
		end
	end

	`SMWC_ASSERT_IMPLY(a_idle_holds_nothing, clk, arst_n, !ca_q, hm_q == '0 && hk_q == '0)
	`SMWC_ASSERT_IMPLY(a_timer_needs_cycle, clk, arst_n, tr_q, ca_q)
	`SMWC_ASSERT_NEXT(a_press_starts_cycle, clk, arst_n,
		push && item.kind == KIND_HOTKEY_PRESS, ca_q && !tr_q)

endmodule

// File: rtl/smwc_queue.sv
// Short queue of result plans between the front and the back end.
// Depends on smwc_pkg for the plan type and the queue depth.
module smwc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  smwc_pkg::plan_t push_plan,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output smwc_pkg::plan_t head
);
	import smwc_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

	plan_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;

	assign full       = cnt_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_plan;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: rtl/smwc_back.sv
// Back end: walks the plan at the queue head and sends one result per cycle,
// unless out_ready stalls it, through a registered output. Depends on smwc_pkg.
module smwc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  smwc_pkg::plan_t     head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output smwc_pkg::out_item_t out_item
);
	import smwc_pkg::*;
	`include "sticky_modifier_window_cycler_top_assert.svh"

	logic [CNT_W-1:0] idx_q;
	logic             ov_q;
	out_item_t        res_q;
	logic             load, at_end;

	// Load whenever a plan is at the head and the output register is empty or being emptied.
	assign load      = head_valid && (!ov_q || out_ready);
	assign at_end    = idx_q == head.cnt - 1'b1;
	assign pop       = load && at_end;
	assign out_valid = ov_q;
	assign out_item  = res_q;

	always_ff @(posedge clk) begin
		if (load)
			res_q <= head.slot[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
			if (load)
				idx_q <= at_end ? '0 : idx_q + 1'b1;
		end
	end

	`SMWC_ASSERT_IMPLY(a_plan_nonempty, clk, arst_n, head_valid, head.cnt != '0)
	`SMWC_ASSERT_IMPLY(a_idx_in_plan, clk, arst_n, head_valid, idx_q < head.cnt)
	`SMWC_ASSERT_IMPLY(a_mid_plan_out_busy, clk, arst_n, idx_q != '0, ov_q)

endmodule
